### design/ple_pkg.sv
// Shared types and constants for the positional list engine.
`default_nettype none

package ple_pkg;

  localparam int POS_BITS   = 6;
  localparam int COUNT_BITS = 6;

  typedef enum logic [1:0] {
    MODE_READ   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2
  } mode_t;

  typedef struct packed {
    logic                ins;
    logic                del;
    logic [POS_BITS-1:0] pos0;
  } cell_ctl_t;

endpackage

`default_nettype wire

### design/ple_cell.sv
// One list cell: holds a word and shifts with its neighbors on insert or delete.
`default_nettype none

module ple_cell #(
  parameter int IDX       = 0,
  parameter int DATA_BITS = 32
) (
  input  wire logic                 clk,
  input  wire ple_pkg::cell_ctl_t   ctl,
  input  wire logic [DATA_BITS-1:0] new_data,
  input  wire logic [DATA_BITS-1:0] left_data,
  input  wire logic [DATA_BITS-1:0] right_data,
  output logic      [DATA_BITS-1:0] data,
  output logic      [DATA_BITS-1:0] sel_data
);

  localparam logic [31:0] IDX_W = 32'(IDX);

  logic [DATA_BITS-1:0] data_r;
  logic [DATA_BITS-1:0] data_nxt;
  logic [31:0]          pos_w;
  logic                 hit;
  logic                 above;

  assign pos_w = 32'(ctl.pos0);
  assign hit   = (IDX_W == pos_w);
  assign above = (IDX_W > pos_w);

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (hit) begin
        data_nxt = new_data;
      end else if (above) begin
        data_nxt = left_data;
      end
    end else if (ctl.del) begin
      if (hit || above) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data     = data_r;
  assign sel_data = hit ? data_r : '0;

endmodule

`default_nettype wire

### design/positional_list_engine_core.sv
// Top level of the positional list engine: control, fill count, cell row and result register.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_mode, in_position, in_value
//   out     | output    | out_valid/out_stall| out_status, out_read_value, out_count,
//           |           |                    | out_is_empty
//
// One transaction per cycle unless stalled: every cell updates in parallel and the result is
// registered in the cycle after acceptance. The read path is a select across the cell row.
// Reset clears the fill count and the result valid; cell contents are left as they are.
// The input stalls only while a result waits in the output register and out_stall is high.
`default_nettype none

module positional_list_engine_core #(
  parameter int DEPTH     = 32,
  parameter int DATA_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [ple_pkg::POS_BITS-1:0]  in_position,
  input  wire logic [DATA_BITS-1:0]          in_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_status,
  output logic [DATA_BITS-1:0]               out_read_value,
  output logic [ple_pkg::COUNT_BITS-1:0]     out_count,
  output logic                               out_is_empty
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > ple_pkg::POS_BITS) ? CW : ple_pkg::POS_BITS) + 1;
  localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

  logic [CW-1:0]               cnt_r;
  logic [CW-1:0]               cnt_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic                        out_status_r;
  logic [DATA_BITS-1:0]        out_read_value_r;
  logic [ple_pkg::COUNT_BITS-1:0] out_count_r;
  logic                        out_is_empty_r;

  logic                        accept;
  logic [CMPW-1:0]             n_e;
  logic [CMPW-1:0]             pos_e;
  logic                        ok;
  logic                        is_ins;
  logic                        is_rd;
  logic [CMPW-1:0]             cnt_nxt_e;
  logic [DATA_BITS-1:0]        sel_or;
  ple_pkg::cell_ctl_t          ctl;

  logic [DATA_BITS-1:0] cell_q   [DEPTH];
  logic [DATA_BITS-1:0] cell_sel [DEPTH];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign n_e      = CMPW'(cnt_r);
  assign pos_e    = CMPW'(in_position);

  always_comb begin
    ok     = 1'b0;
    is_ins = 1'b0;
    is_rd  = 1'b0;
    unique case (in_mode)
      ple_pkg::MODE_READ: begin
        is_rd = 1'b1;
        ok    = (pos_e != '0) && (pos_e <= n_e);
      end
      ple_pkg::MODE_INSERT: begin
        is_ins = 1'b1;
        ok     = (n_e < DEPTH_C) && (pos_e != '0) && (pos_e <= n_e + 1'b1);
      end
      ple_pkg::MODE_DELETE: begin
        ok = (n_e != '0) && (pos_e != '0) && (pos_e <= n_e);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign ctl.ins  = accept && ok && is_ins;
  assign ctl.del  = accept && ok && !is_ins && !is_rd;
  assign ctl.pos0 = in_position - 1'b1;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DATA_BITS-1:0] left_d;
      logic [DATA_BITS-1:0] right_d;
      if (gi == 0) begin : g_first
        assign left_d = in_value;
      end else begin : g_mid_l
        assign left_d = cell_q[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_d = '0;
      end else begin : g_mid_r
        assign right_d = cell_q[gi+1];
      end
      ple_cell #(
        .IDX       (gi),
        .DATA_BITS (DATA_BITS)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .new_data   (in_value),
        .left_data  (left_d),
        .right_data (right_d),
        .data       (cell_q[gi]),
        .sel_data   (cell_sel[gi])
      );
    end
  endgenerate

  always_comb begin
    sel_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_or = sel_or | cell_sel[i];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.ins) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (ctl.del) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  assign cnt_nxt_e     = CMPW'(cnt_nxt);
  assign out_valid_nxt = accept ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r     <= !ok;
      out_read_value_r <= (ok && !is_ins) ? sel_or : '0;
      out_count_r      <= cnt_nxt_e[ple_pkg::COUNT_BITS-1:0];
      out_is_empty_r   <= (cnt_nxt == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = out_count_r;
  assign out_is_empty   = out_is_empty_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(cnt_r) <= DEPTH_C)
    else $error("fill count above depth");

  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !ok) |=> $stable(cnt_r))
    else $error("count changed on rejected transaction");

  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> (cnt_r == CW'($past(cnt_r) + 1'b1)))
    else $error("insert did not grow count");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_read_value_r == '0))
    else $error("error result carries data");

endmodule

`default_nettype wire
